[rtl/core/kpi_pkg.sv]
// Package with the shared types and codes of the keyframe pose interpolator.
`default_nettype none
package kpi_pkg;

   localparam int NCH = 6;
   localparam int DIV_STEPS = 49;

   localparam logic [2:0] FUNC_POSE   = 3'd0;
   localparam logic [2:0] FUNC_FRAMES = 3'd1;
   localparam logic [2:0] FUNC_KCOUNT = 3'd2;
   localparam logic [2:0] FUNC_OFFSET = 3'd3;
   localparam logic [2:0] FUNC_START  = 3'd4;
   localparam logic [2:0] FUNC_TICK   = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FRAME,
      S_RDA,
      S_LOAD,
      S_RDB,
      S_MUL,
      S_DIVL,
      S_DIV,
      S_SUM,
      S_EMIT,
      S_ADV
   } state_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic tick_init;
      logic rd_frame;
      logic rd_a;
      logic rd_b;
      logic cap_a;
      logic store_start;
      logic mul;
      logic div_load;
      logic div_step;
      logic sum;
      logic next_chan;
      logic next_part;
      logic emit;
      logic adv;
   } cmd_type;

   typedef struct packed {
      logic start_ok;
      logic no_parts;
      logic chan_last;
      logic part_last;
      logic frames_zero;
      logic div_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/kpi_controller.sv]
// Sequencer that steps the datapath through table writes, starts and ticks.
`default_nettype none
module kpi_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_func,
   input  wire kpi_pkg::status_type status,
   output kpi_pkg::cmd_type        cmd
);
   import kpi_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic tick_mode_ff;
   logic tick_mode_in;
   logic accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_mode_ff <= tick_mode_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      tick_mode_in = tick_mode_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_START && status.start_ok) begin
                  tick_mode_in = 1'b0;
                  state_in = status.no_parts ? S_IDLE : S_RDA;
               end else if (req_func == FUNC_TICK) begin
                  tick_mode_in = 1'b1;
                  state_in = S_FRAME;
               end
            end
         end
         S_FRAME: state_in = status.no_parts ? S_ADV : S_RDA;
         S_RDA:   state_in = tick_mode_ff ? S_RDB : S_LOAD;
         S_LOAD:  state_in = status.chan_last ? S_EMIT : S_RDA;
         S_RDB:   state_in = S_MUL;
         S_MUL:   state_in = S_DIVL;
         S_DIVL:  state_in = status.frames_zero ? S_SUM : S_DIV;
         S_DIV:   state_in = status.div_done ? S_SUM : S_DIV;
         S_SUM:   state_in = status.chan_last ? S_EMIT : S_RDA;
         S_EMIT: begin
            if (status.out_free) begin
               if (status.part_last) begin
                  state_in = tick_mode_ff ? S_ADV : S_IDLE;
               end else begin
                  state_in = S_RDA;
               end
            end
         end
         S_ADV:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = accept;
            cmd.start = accept && req_func == FUNC_START && status.start_ok;
            cmd.tick_init = accept && req_func == FUNC_TICK;
         end
         S_FRAME: cmd.rd_frame = 1'b1;
         S_RDA:   cmd.rd_a = 1'b1;
         S_LOAD: begin
            cmd.store_start = 1'b1;
            cmd.next_chan = !status.chan_last;
         end
         S_RDB: begin
            cmd.rd_b = 1'b1;
            cmd.cap_a = 1'b1;
         end
         S_MUL:  cmd.mul = 1'b1;
         S_DIVL: cmd.div_load = 1'b1;
         S_DIV:  cmd.div_step = 1'b1;
         S_SUM: begin
            cmd.sum = 1'b1;
            cmd.next_chan = !status.chan_last;
         end
         S_EMIT: begin
            cmd.emit = status.out_free;
            cmd.next_part = status.out_free && !status.part_last;
         end
         S_ADV:   cmd.adv = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/kpi_datapath.sv]
// Keyframe tables, key and frame counters, multiplier, divider and result register.
`default_nettype none
module kpi_datapath #(
   parameter int MAX_PARTS = 16,
   parameter int MAX_KEYS = 16,
   parameter int MAX_MOTIONS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire kpi_pkg::cmd_type    cmd,
   output kpi_pkg::status_type      status,
   input  wire logic [2:0]          req_func,
   input  wire logic [2:0]          req_motion,
   input  wire logic [3:0]          req_key,
   input  wire logic [3:0]          req_part,
   input  wire logic [2:0]          req_channel,
   input  wire logic signed [31:0]  req_value,
   input  wire logic [15:0]         req_frames,
   input  wire logic [4:0]          req_key_count,
   input  wire logic                csr_write_enable,
   input  wire logic [4:0]          csr_write_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [3:0]               rsp_part_index,
   output logic signed [31:0]       rsp_pos_x,
   output logic signed [31:0]       rsp_pos_y,
   output logic signed [31:0]       rsp_pos_z,
   output logic signed [31:0]       rsp_rot_x,
   output logic signed [31:0]       rsp_rot_y,
   output logic signed [31:0]       rsp_rot_z,
   output logic                     rsp_last
);
   import kpi_pkg::*;

   localparam int MW = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;
   localparam int KW = $clog2(MAX_KEYS);
   localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int AW = MW + KW + PW + 3;
   localparam int OW = PW + 3;
   localparam int FW = MW + KW;
   localparam int PLIM = (MAX_PARTS < 16) ? MAX_PARTS : 16;

   logic signed [31:0] pose_mem [0:(1 << AW) - 1];
   logic signed [31:0] off_mem [0:(1 << OW) - 1];
   logic [15:0] frame_mem [0:(1 << FW) - 1];
   logic [4:0] kcount_ff [0:MAX_MOTIONS - 1];

   logic [4:0] num_parts_ff, num_parts_in;
   logic [MW-1:0] am_ff, am_in;
   logic [KW-1:0] ck_ff, ck_in, nk_ff, nk_in;
   logic [15:0] fc_ff, fc_in;
   logic [3:0] part_ff, part_in;
   logic [2:0] chan_ff, chan_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] pose_rd_ff, off_rd_ff, a_ff, off_ff;
   logic [15:0] frame_rd_ff;
   logic prod_neg_ff;
   logic [48:0] prod_mag_ff, quo_ff;
   logic [15:0] rem_ff;
   logic [5:0] div_cnt_ff;
   logic signed [31:0] stage_ff [0:NCH-1];

   logic [7:0] m_ext, k_ext, p_ext, cur_p_ext;
   logic motion_ok, key_ok, part_ok, chan_ok;
   logic [AW-1:0] wr_pose_addr, rd_pose_addr;
   logic [OW-1:0] wr_off_addr, rd_off_addr;
   logic [FW-1:0] wr_frame_addr, rd_frame_addr;
   logic [4:0] n_eff;
   logic [7:0] kc_eff, ck_inc, nk_inc;
   logic [16:0] fc_inc;
   logic signed [32:0] delta;
   logic signed [49:0] prod_w, prod_abs;
   logic [16:0] rem_sh;
   logic rem_ge;
   logic signed [50:0] term, total;
   logic signed [31:0] sat_val;

   assign m_ext = 8'(req_motion);
   assign k_ext = 8'(req_key);
   assign p_ext = 8'(req_part);
   assign cur_p_ext = 8'(part_ff);
   assign motion_ok = m_ext < 8'(MAX_MOTIONS);
   assign key_ok = k_ext < 8'(MAX_KEYS);
   assign part_ok = p_ext < 8'(MAX_PARTS);
   assign chan_ok = req_channel < 3'(NCH);

   assign wr_pose_addr = {m_ext[MW-1:0], k_ext[KW-1:0], p_ext[PW-1:0], req_channel};
   assign wr_off_addr = {p_ext[PW-1:0], req_channel};
   assign wr_frame_addr = {m_ext[MW-1:0], k_ext[KW-1:0]};
   assign rd_pose_addr = {am_ff, cmd.rd_b ? nk_ff : ck_ff, cur_p_ext[PW-1:0], chan_ff};
   assign rd_off_addr = {cur_p_ext[PW-1:0], chan_ff};
   assign rd_frame_addr = {am_ff, ck_ff};

   assign n_eff = (num_parts_ff > 5'(PLIM)) ? 5'(PLIM) : num_parts_ff;
   assign kc_eff = (8'(kcount_ff[am_ff]) > 8'(MAX_KEYS)) ? 8'(MAX_KEYS)
                                                        : 8'(kcount_ff[am_ff]);
   assign ck_inc = 8'(ck_ff) + 8'd1;
   assign nk_inc = 8'(nk_ff) + 8'd1;
   assign fc_inc = {1'b0, fc_ff} + 17'd1;

   assign status.start_ok = motion_ok;
   assign status.no_parts = (n_eff == 5'd0);
   assign status.chan_last = (chan_ff == 3'(NCH - 1));
   assign status.part_last = ({1'b0, part_ff} + 5'd1 == n_eff);
   assign status.frames_zero = (frame_rd_ff == 16'd0);
   assign status.div_done = (div_cnt_ff == 6'd0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.accept && req_func == FUNC_POSE && motion_ok && key_ok && part_ok
          && chan_ok) begin
         pose_mem[wr_pose_addr] <= req_value;
      end
      if (cmd.rd_a || cmd.rd_b) begin
         pose_rd_ff <= pose_mem[rd_pose_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_func == FUNC_OFFSET && part_ok && chan_ok) begin
         off_mem[wr_off_addr] <= req_value;
      end
      if (cmd.rd_a) begin
         off_rd_ff <= off_mem[rd_off_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_func == FUNC_FRAMES && motion_ok && key_ok) begin
         frame_mem[wr_frame_addr] <= req_frames;
      end
      if (cmd.rd_frame) begin
         frame_rd_ff <= frame_mem[rd_frame_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_func == FUNC_KCOUNT && motion_ok) begin
         kcount_ff[m_ext[MW-1:0]] <= req_key_count;
      end
   end

   always_comb begin
      num_parts_in = csr_write_enable ? csr_write_data : num_parts_ff;
      am_in = am_ff;
      ck_in = ck_ff;
      nk_in = nk_ff;
      fc_in = fc_ff;
      part_in = part_ff;
      chan_in = chan_ff;
      if (cmd.start) begin
         am_in = m_ext[MW-1:0];
         ck_in = '0;
         nk_in = KW'(1);
         fc_in = '0;
      end
      if (cmd.adv) begin
         if (fc_inc >= {1'b0, frame_rd_ff}) begin
            fc_in = '0;
            ck_in = (ck_inc >= kc_eff) ? '0 : ck_inc[KW-1:0];
            nk_in = (nk_inc >= kc_eff) ? '0 : nk_inc[KW-1:0];
         end else begin
            fc_in = fc_inc[15:0];
         end
      end
      if (cmd.start || cmd.tick_init) begin
         part_in = '0;
         chan_in = '0;
      end
      if (cmd.next_chan) begin
         chan_in = chan_ff + 3'd1;
      end
      if (cmd.next_part) begin
         part_in = part_ff + 4'd1;
         chan_in = '0;
      end
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff <= 5'd1;
         am_ff <= '0;
         ck_ff <= '0;
         nk_ff <= KW'(1);
         fc_ff <= '0;
         part_ff <= '0;
         chan_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_parts_ff <= num_parts_in;
         am_ff <= am_in;
         ck_ff <= ck_in;
         nk_ff <= nk_in;
         fc_ff <= fc_in;
         part_ff <= part_in;
         chan_ff <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign delta = 33'(pose_rd_ff) - 33'(a_ff);
   assign prod_w = delta * $signed({1'b0, fc_ff});
   assign prod_abs = prod_w[49] ? -prod_w : prod_w;
   assign rem_sh = {rem_ff, quo_ff[48]};
   assign rem_ge = rem_sh >= {1'b0, frame_rd_ff};
   assign term = status.frames_zero ? '0 :
                 (prod_neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff}));
   assign total = 51'(off_ff) + 51'(a_ff) + term;

   always_comb begin
      if (total > 51'sd2147483647) begin
         sat_val = 32'sh7FFFFFFF;
      end else if (total < -51'sd2147483648) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val = total[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         a_ff <= pose_rd_ff;
         off_ff <= off_rd_ff;
      end
      if (cmd.mul) begin
         prod_neg_ff <= prod_w[49];
         prod_mag_ff <= prod_abs[48:0];
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= prod_mag_ff;
         div_cnt_ff <= 6'(DIV_STEPS - 1);
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? 16'(rem_sh - {1'b0, frame_rd_ff}) : rem_sh[15:0];
         quo_ff <= {quo_ff[47:0], rem_ge};
         div_cnt_ff <= div_cnt_ff - 6'd1;
      end
      if (cmd.store_start) begin
         stage_ff[chan_ff] <= pose_rd_ff;
      end else if (cmd.sum) begin
         stage_ff[chan_ff] <= sat_val;
      end
      if (cmd.emit) begin
         rsp_part_index <= part_ff;
         rsp_pos_x <= stage_ff[0];
         rsp_pos_y <= stage_ff[1];
         rsp_pos_z <= stage_ff[2];
         rsp_rot_x <= stage_ff[3];
         rsp_rot_y <= stage_ff[4];
         rsp_rot_z <= stage_ff[5];
         rsp_last <= status.part_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Result loaded over a beat that was not taken.");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (8'(ck_ff) < 8'(MAX_KEYS) && 8'(nk_ff) < 8'(MAX_KEYS)))
      else $error("Key index left the key table.");

   a_div_load: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> div_cnt_ff == 6'(DIV_STEPS - 1))
      else $error("Divider did not load its step count.");

endmodule
`default_nettype wire

[rtl/core/keyframe_pose_interpolator.sv]
// Top level of the keyframe pose interpolator.
// A tick reads each pose channel of a part, multiplies it and divides it in the bit-serial
// divider (49 steps per channel), then sums it; the divider is skipped when the current
// key's frame count is zero. Six channels are done per part before the part is output,
// with a frame read before the parts and a key advance after them. A start reads and
// loads each channel, then outputs the part.
// Table writes and part-count writes take effect without a busy state. Results leave
// one part per beat, last set on the final part of a step.
`default_nettype none
module keyframe_pose_interpolator #(
   parameter int MAX_PARTS = 16,
   parameter int MAX_KEYS = 16,
   parameter int MAX_MOTIONS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_func,
   input  wire logic [2:0]         req_motion,
   input  wire logic [3:0]         req_key,
   input  wire logic [3:0]         req_part,
   input  wire logic [2:0]         req_channel,
   input  wire logic signed [31:0] req_value,
   input  wire logic [15:0]        req_frames,
   input  wire logic [4:0]         req_key_count,
   input  wire logic               csr_write_enable,
   input  wire logic [4:0]         csr_write_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_part_index,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic signed [31:0]      rsp_rot_x,
   output logic signed [31:0]      rsp_rot_y,
   output logic signed [31:0]      rsp_rot_z,
   output logic                    rsp_last
);
   import kpi_pkg::*;

   cmd_type cmd;
   status_type status;

   kpi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   kpi_datapath #(
      .MAX_PARTS   (MAX_PARTS),
      .MAX_KEYS    (MAX_KEYS),
      .MAX_MOTIONS (MAX_MOTIONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_motion       (req_motion),
      .req_key          (req_key),
      .req_part         (req_part),
      .req_channel      (req_channel),
      .req_value        (req_value),
      .req_frames       (req_frames),
      .req_key_count    (req_key_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_part_index   (rsp_part_index),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_rot_x        (rsp_rot_x),
      .rsp_rot_y        (rsp_rot_y),
      .rsp_rot_z        (rsp_rot_z),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

[dv/keyframe_pose_interpolator_test.sv]
// Self-checking testbench for the keyframe pose interpolator with a built-in pose predictor.
`default_nettype none
module keyframe_pose_interpolator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import kpi_pkg::*;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam logic [2:0] CHAN_BAD = 3'd6;
   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 6000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [2:0] func;
      logic [2:0] motion;
      logic [3:0] key;
      logic [3:0] part;
      logic [2:0] channel;
      logic signed [31:0] value;
      logic [15:0] frames;
      logic [4:0] key_count;
   } req_beat_type;

   typedef struct {
      logic [3:0] part_index;
      logic signed [31:0] ch [6];
      logic last;
   } pose_type;

   typedef struct {
      req_beat_type beat;
      bit typed;
      pose_type want;
   } step_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_func = 0;
   logic [2:0] req_motion = 0;
   logic [3:0] req_key = 0;
   logic [3:0] req_part = 0;
   logic [2:0] req_channel = 0;
   logic signed [31:0] req_value = 0;
   logic [15:0] req_frames = 0;
   logic [4:0] req_key_count = 0;
   logic csr_write_enable = 0;
   logic [4:0] csr_write_data = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [3:0] rsp_part_index;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_last;

   keyframe_pose_interpolator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_motion(req_motion), .req_key(req_key), .req_part(req_part),
      .req_channel(req_channel), .req_value(req_value), .req_frames(req_frames),
      .req_key_count(req_key_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_part_index(rsp_part_index),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_rot_x(rsp_rot_x), .rsp_rot_y(rsp_rot_y), .rsp_rot_z(rsp_rot_z),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state.
   int key_pose [8][16][16][6];
   bit key_pose_set [8][16][16][6];
   int key_frames [8][16];
   bit key_frames_set [8][16];
   int motion_keys [8];
   bit motion_keys_set [8];
   int start_offset [16][6];
   bit start_offset_set [16][6];
   int motion_sel, key_now, key_next, frame_count, part_count;

   pose_type expected_poses [$];
   int mismatches = 0;
   int burst_left = 0;
   bit hold_req = 0;
   int idle_cycles = 0;

   function automatic int parts_active();
      return part_count > 16 ? 16 : part_count;
   endfunction

   function automatic logic signed [31:0] saturate(input longint s);
      if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -64'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic void predict_poses(input req_beat_type b, ref pose_type outs[$]);
      pose_type r;
      int n, fr, cnt;
      longint a, z, term;
      n = parts_active();
      case (b.func)
         FUNC_POSE: if (b.channel < 6) begin
            key_pose[b.motion][b.key][b.part][b.channel] = b.value;
            key_pose_set[b.motion][b.key][b.part][b.channel] = 1;
         end
         FUNC_FRAMES: begin
            key_frames[b.motion][b.key] = b.frames;
            key_frames_set[b.motion][b.key] = 1;
         end
         FUNC_KCOUNT: begin
            motion_keys[b.motion] = b.key_count;
            motion_keys_set[b.motion] = 1;
         end
         FUNC_OFFSET: if (b.channel < 6) begin
            start_offset[b.part][b.channel] = b.value;
            start_offset_set[b.part][b.channel] = 1;
         end
         FUNC_START: begin
            motion_sel = b.motion;
            key_now = 0;
            key_next = 1;
            frame_count = 0;
            for (int i = 0; i < n; i++) begin
               r.part_index = 4'(i);
               for (int c = 0; c < 6; c++) r.ch[c] = key_pose[motion_sel][0][i][c];
               r.last = (i + 1 == n);
               outs.push_back(r);
            end
         end
         FUNC_TICK: begin
            fr = key_frames[motion_sel][key_now];
            cnt = motion_keys[motion_sel] > 16 ? 16 : motion_keys[motion_sel];
            for (int i = 0; i < n; i++) begin
               r.part_index = 4'(i);
               for (int c = 0; c < 6; c++) begin
                  a = key_pose[motion_sel][key_now][i][c];
                  z = key_pose[motion_sel][key_next][i][c];
                  term = (fr != 0) ? ((z - a) * longint'(frame_count)) / longint'(fr) : 0;
                  r.ch[c] = saturate(longint'(start_offset[i][c]) + a + term);
               end
               r.last = (i + 1 == n);
               outs.push_back(r);
            end
            frame_count++;
            if (frame_count >= fr) begin
               frame_count = 0;
               key_now = key_now + 1;
               key_next = key_next + 1;
               if (key_next >= cnt) key_next = 0;
               if (key_now >= cnt) key_now = 0;
            end
            frame_count &= 16'hFFFF;
         end
         default: ;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_value();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
   endfunction

   function automatic req_beat_type mk(input logic [2:0] f, input logic [2:0] m,
                                       input logic [3:0] k, input logic [3:0] p,
                                       input logic [2:0] c, input logic signed [31:0] v,
                                       input logic [15:0] fr, input logic [4:0] kc);
      req_beat_type b;
      b.func = f; b.motion = m; b.key = k; b.part = p;
      b.channel = c; b.value = v; b.frames = fr; b.key_count = kc;
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b, input bit typed, input pose_type want);
      pose_type outs [$];
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_func <= b.func; req_motion <= b.motion; req_key <= b.key; req_part <= b.part;
      req_channel <= b.channel; req_value <= b.value; req_frames <= b.frames;
      req_key_count <= b.key_count;
      do @(posedge clock); while (req_stall);
      predict_poses(b, outs);
      if (typed) expected_poses.push_back(want);
      else foreach (outs[i]) expected_poses.push_back(outs[i]);
   endtask

   // Writes every table entry that the coming start or tick reads and that is still blank.
   task automatic fill_tables(input req_beat_type b);
      pose_type none;
      int n, m;
      n = parts_active();
      if (b.func == FUNC_START) begin
         for (int i = 0; i < n; i++)
            for (int c = 0; c < 6; c++)
               if (!key_pose_set[b.motion][0][i][c])
                  send_beat(mk(FUNC_POSE, b.motion, 4'd0, 4'(i), 3'(c), rand_value(),
                               16'd0, 5'd0), 1'b0, none);
      end else if (b.func == FUNC_TICK) begin
         m = motion_sel;
         if (!motion_keys_set[m])
            send_beat(mk(FUNC_KCOUNT, 3'(m), 4'd0, 4'd0, 3'd0, 32'sd0, 16'd0,
                         5'($urandom_range(1, 4))), 1'b0, none);
         if (!key_frames_set[m][key_now])
            send_beat(mk(FUNC_FRAMES, 3'(m), 4'(key_now), 4'd0, 3'd0, 32'sd0,
                         16'($urandom_range(0, 4)), 5'd0), 1'b0, none);
         for (int i = 0; i < n; i++)
            for (int c = 0; c < 6; c++) begin
               if (!start_offset_set[i][c])
                  send_beat(mk(FUNC_OFFSET, 3'd0, 4'd0, 4'(i), 3'(c), rand_value(),
                               16'd0, 5'd0), 1'b0, none);
               if (!key_pose_set[m][key_now][i][c])
                  send_beat(mk(FUNC_POSE, 3'(m), 4'(key_now), 4'(i), 3'(c), rand_value(),
                               16'd0, 5'd0), 1'b0, none);
               if (!key_pose_set[m][key_next][i][c])
                  send_beat(mk(FUNC_POSE, 3'(m), 4'(key_next), 4'(i), 3'(c), rand_value(),
                               16'd0, 5'd0), 1'b0, none);
            end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      burst_left = 0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_part_count(input logic [4:0] value);
      wait_drained();
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      part_count = value;
   endtask

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int pick;
      b = mk(3'($urandom_range(0, 5)), 3'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
             4'($urandom_range(0, 15)), 3'($urandom_range(0, 5)), rand_value(), 16'd0, 5'd0);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
         b.motion = 3'($urandom_range(0, 7));
         b.key = 4'($urandom_range(0, 15));
      end
      if (pick < 35) b.func = FUNC_TICK;
      else if (pick < 45) b.func = FUNC_START;
      else if (pick < 70) b.func = FUNC_POSE;
      else if (pick < 80) b.func = FUNC_FRAMES;
      else if (pick < 88) b.func = FUNC_KCOUNT;
      else if (pick < 95) b.func = FUNC_OFFSET;
      else begin
         b.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
         if ($urandom_range(0, 1)) begin
            b.func = $urandom_range(0, 1) ? FUNC_POSE : FUNC_OFFSET;
            b.channel = 3'($urandom_range(CHAN_BAD, 7));
         end
      end
      pick = $urandom_range(0, 9);
      b.frames = pick < 7 ? 16'($urandom_range(0, 4)) :
                 pick < 9 ? 16'($urandom_range(5, 40)) : 16'($urandom);
      b.key_count = $urandom_range(0, 2) != 0 ? 5'($urandom_range(1, 4)) :
                                                5'($urandom_range(0, 31));
      return b;
   endfunction

   initial begin
      step_row_type rows [$];
      step_row_type row;
      pose_type none;
      logic [4:0] phase_parts [6];
      int phase_items;

      motion_sel = 0; key_now = 0; key_next = 1; frame_count = 0; part_count = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      row.typed = 0;
      row.beat = mk(FUNC_POSE, 0, 0, 0, 0, 32'sh7FFFFFFF, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 0, 0, 0, 1, 32'sh80000000, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 0, 0, 0, 2, 32'sd1, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 0, 0, 0, 3, -32'sd1, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 0, 0, 0, 4, 32'sd0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 0, 0, 0, 5, 32'sh00010000, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 0, 0, 0, CHAN_BAD, 32'sh12345678, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_START, 0, 0, 0, 0, 0, 0, 0);
      row.typed = 1;
      row.want.part_index = 0;
      row.want.ch = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd1, -32'sd1, 32'sd0, 32'sh00010000};
      row.want.last = 1;
      rows.push_back(row);
      row.typed = 0;
      row.beat = mk(FUNC_KCOUNT, 0, 0, 0, 0, 0, 0, 2); rows.push_back(row);
      row.beat = mk(FUNC_FRAMES, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_FRAMES, 0, 1, 0, 0, 0, 16'hFFFF, 0); rows.push_back(row);
      row.beat = mk(FUNC_OFFSET, 0, 0, 0, 0, 32'sh7FFFFFFF, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_OFFSET, 0, 0, 0, 1, 32'sh80000000, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_SPARE_LO, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_SPARE_HI, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_KCOUNT, 1, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_START, 1, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_KCOUNT, 1, 0, 0, 0, 0, 0, 31); rows.push_back(row);
      row.beat = mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_POSE, 7, 15, 15, 5, 32'sh7FFFFFFF, 0, 0); rows.push_back(row);
      row.beat = mk(FUNC_START, 7, 0, 0, 0, 0, 0, 0); rows.push_back(row);

      foreach (rows[i]) begin
         fill_tables(rows[i].beat);
         send_beat(rows[i].beat, rows[i].typed, rows[i].want);
      end

      // Full part count phases run short since every new key costs a table fill.
      phase_parts = '{5'd16, 5'd31, 5'd0, 5'd3, 5'd1, 5'd0};
      phase_parts[5] = 5'($urandom_range(1, 8));
      foreach (phase_parts[ph]) begin
         write_part_count(phase_parts[ph]);
         if (ph == 0) hold_req = 1;
         phase_items = phase_parts[ph] >= 16 ? 10 : 30;
         repeat (phase_items) begin
            row.beat = random_beat();
            fill_tables(row.beat);
            send_beat(row.beat, 0, none);
         end
      end

      wait_drained();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver stall pattern, with one long hold-off to back the block up.
   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_req) begin
            rsp_stall <= 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 0;
            rsp_stall <= 0;
         end else begin
            case ((cyc / 300) % 4)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= cyc[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      pose_type want;
      logic signed [31:0] got [6];
      bit bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_rot_x, rsp_rot_y, rsp_rot_z};
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose beat for part %0d", rsp_part_index);
         end else begin
            want = expected_poses.pop_front();
            bad = (want.part_index !== rsp_part_index) || (want.last !== rsp_last);
            for (int c = 0; c < 6; c++) if (want.ch[c] !== got[c]) bad = 1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"pose mismatch: exp part %0d %h %h %h %h %h %h last %b, ",
                            "got part %0d %h %h %h %h %h %h last %b"},
                           want.part_index, want.ch[0], want.ch[1], want.ch[2], want.ch[3],
                           want.ch[4], want.ch[5], want.last, rsp_part_index, got[0], got[1],
                           got[2], got[3], got[4], got[5], rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else if (idle_cycles == IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

endmodule
`default_nettype wire
